### src/tsrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tsrs_pkg;

    localparam logic [7:0] TAB_CHAR  = 8'd9;
    localparam logic [7:0] NUL_CHAR  = 8'd0;

    localparam logic OP_PARSE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef enum logic [1:0] {
        PH_SUM_FIRST = 2'd0,
        PH_SUM_REST  = 2'd1,
        PH_DATE      = 2'd2
    } t_phase;

    typedef struct packed {
        logic       opcode;
        logic [7:0] data_byte;
        logic       last_byte;
        logic [2:0] read_record;
        logic       read_is_date;
        logic [3:0] read_position;
        logic [2:0] current_selection;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_char;
        logic       done_res;
        logic [2:0] record_count;
        logic [2:0] selection;
    } t_out_item;

endpackage

`default_nettype wire

### src/tsrs_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tsrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### src/tab_separated_record_splitter_core.sv
// tab separated record splitter
// input channel (i_in_valid / o_in_stall / i_in_item): one item per byte of a
// received buffer (opcode parse) or one character read from the store (opcode
// read). the buffer reads summary TAB date TAB summary TAB date ..., at most
// MAX_RECORDS records, each field kept up to FIELD_CHARS characters.
// output channel (o_out_valid / i_out_stall / o_out_item): exactly one item for
// every accepted input item, in order. a read returns the stored character or
// zero past the field length; a parse item marked last_byte returns the record
// count and the clamped selection, then parsing starts over.
// the store is read at accept and the registered read data is resolved in a
// second stage before the output register. throughput is one item per cycle
// while the receiver does not stall, set by the single write port of each store
// (one character and one length row per item).
// while the receiver stalls, the output register holds its item and the middle
// stage can still fill, so one more item is taken before o_in_stall rises.
// reset (synchronous, active low) clears the parse state and the pipeline; the
// character and length stores are not cleared and a field that was never
// written reads undefined.
`timescale 1ns / 1ps
`default_nettype none

module tab_separated_record_splitter_core #(
    parameter int MAX_RECORDS = 5,
    parameter int FIELD_CHARS = 15
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire tsrs_pkg::t_in_item    i_in_item,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output tsrs_pkg::t_out_item        o_out_item
);

    localparam int FIELD_COUNT = MAX_RECORDS * 2;
    localparam int CHAR_DEPTH  = FIELD_COUNT * FIELD_CHARS;
    localparam int CAW         = (CHAR_DEPTH > 1) ? $clog2(CHAR_DEPTH) : 1;
    localparam int RW          = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int SW          = $clog2(MAX_RECORDS + 1);
    localparam int FW          = RW + 1;
    localparam int CW          = $clog2(FIELD_CHARS + 1);

    // parse state
    tsrs_pkg::t_phase r_phase, n_phase;
    logic [SW-1:0]    r_slot, n_slot;
    logic [CW-1:0]    r_cp, n_cp;
    logic [SW-1:0]    r_complete, n_complete;
    logic             r_stopped, n_stopped;
    logic [CW-1:0]    r_sum_len, n_sum_len;

    // middle stage
    logic             r_s1_valid;
    logic             r_s1_is_read;
    logic             r_s1_ok;
    logic             r_s1_date;
    logic [3:0]       r_s1_pos;
    logic             r_s1_done;
    logic [2:0]       r_s1_count;
    logic [2:0]       r_s1_sel;

    logic                r_out_valid;
    tsrs_pkg::t_out_item r_out_item;

    logic                advance;
    logic                in_accept;
    logic                is_parse;
    logic                is_read;

    logic                char_we;
    logic [FW-1:0]       char_field;
    logic [CW-1:0]       char_pos;
    logic [CAW-1:0]      char_waddr;
    logic [CAW-1:0]      char_raddr;
    logic [7:0]          char_rdata;

    logic                len_we;
    logic [2*CW-1:0]     len_wdata;
    logic [RW-1:0]       len_waddr;
    logic [RW-1:0]       len_raddr;
    logic [2*CW-1:0]     len_rdata;

    logic [RW-1:0]       slot_lo;
    logic [7:0]          rrec_ext;
    logic [FW-1:0]       rfield;
    logic [CW-1:0]       cp_inc;
    logic                cp_room;

    logic                done;
    logic [7:0]          cnt8;
    logic [7:0]          sel8;
    logic [7:0]          clamp8;

    logic [CW-1:0]       s1_len;
    logic                s1_hit;
    tsrs_pkg::t_out_item s1_item;

    // the middle stage moves whenever the output register can take an item
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign is_parse   = in_accept && (i_in_item.opcode == tsrs_pkg::OP_PARSE);
    assign is_read    = in_accept && (i_in_item.opcode == tsrs_pkg::OP_READ);

    assign slot_lo  = r_slot[RW-1:0];
    assign rrec_ext = {5'b0, i_in_item.read_record};
    assign rfield   = {rrec_ext[RW-1:0], i_in_item.read_is_date};
    assign cp_room  = (int'(r_cp) < FIELD_CHARS);
    assign cp_inc   = cp_room ? (r_cp + 1'b1) : r_cp;

    always_comb begin
        n_phase    = r_phase;
        n_slot     = r_slot;
        n_cp       = r_cp;
        n_complete = r_complete;
        n_stopped  = r_stopped;
        n_sum_len  = r_sum_len;
        char_we    = 1'b0;
        char_field = {slot_lo, 1'b0};
        char_pos   = r_cp;
        len_we     = 1'b0;
        len_wdata  = {{CW{1'b0}}, cp_inc};
        done       = 1'b0;
        cnt8       = 8'd0;
        sel8       = 8'd0;
        clamp8     = 8'd0;
        if (is_parse) begin
            if (!r_stopped) begin
                if (i_in_item.data_byte == tsrs_pkg::NUL_CHAR) begin
                    n_stopped = 1'b1;
                end else begin
                    case (r_phase)
                        tsrs_pkg::PH_SUM_FIRST: begin
                            // first summary byte is text even when it is a tab
                            char_we   = 1'b1;
                            char_pos  = '0;
                            len_we    = 1'b1;
                            len_wdata = {{CW{1'b0}}, CW'(1)};
                            n_cp      = CW'(1);
                            n_phase   = tsrs_pkg::PH_SUM_REST;
                        end
                        tsrs_pkg::PH_SUM_REST: begin
                            if (i_in_item.data_byte == tsrs_pkg::TAB_CHAR) begin
                                n_complete = r_slot + 1'b1;
                                n_phase    = tsrs_pkg::PH_DATE;
                                n_cp       = '0;
                                n_sum_len  = r_cp;
                                len_we     = 1'b1;
                                len_wdata  = {{CW{1'b0}}, r_cp};
                            end else begin
                                char_we   = cp_room;
                                len_we    = cp_room;
                                len_wdata = {{CW{1'b0}}, cp_inc};
                                n_cp      = cp_inc;
                            end
                        end
                        tsrs_pkg::PH_DATE: begin
                            if (i_in_item.data_byte == tsrs_pkg::TAB_CHAR) begin
                                n_slot  = r_slot + 1'b1;
                                n_phase = tsrs_pkg::PH_SUM_FIRST;
                                n_cp    = '0;
                                if (int'(r_slot) + 1 >= MAX_RECORDS) begin
                                    n_stopped = 1'b1;
                                end
                            end else begin
                                char_field = {slot_lo, 1'b1};
                                char_we    = cp_room;
                                len_we     = cp_room;
                                len_wdata  = {cp_inc, r_sum_len};
                                n_cp       = cp_inc;
                            end
                        end
                        default: begin
                            n_phase = tsrs_pkg::PH_SUM_FIRST;
                        end
                    endcase
                end
            end
            if (i_in_item.last_byte) begin
                done   = 1'b1;
                cnt8   = 8'(n_complete);
                sel8   = {5'b0, i_in_item.current_selection};
                clamp8 = sel8;
                if (sel8 >= cnt8) begin
                    clamp8 = (cnt8 == 8'd0) ? 8'd0 : (cnt8 - 8'd1);
                end
                n_phase    = tsrs_pkg::PH_SUM_FIRST;
                n_slot     = '0;
                n_cp       = '0;
                n_complete = '0;
                n_stopped  = 1'b0;
            end
        end
    end

    assign char_waddr = CAW'(int'(char_field) * FIELD_CHARS + int'(char_pos));
    assign char_raddr = CAW'(int'(rfield) * FIELD_CHARS + int'(i_in_item.read_position));
    assign len_waddr  = slot_lo;
    assign len_raddr  = rrec_ext[RW-1:0];

    tsrs_ram #(
        .WIDTH (8),
        .DEPTH (CHAR_DEPTH)
    ) u_char_ram (
        .i_clk   (i_clk),
        .i_we    (char_we),
        .i_waddr (char_waddr),
        .i_wdata (i_in_item.data_byte),
        .i_re    (is_read),
        .i_raddr (char_raddr),
        .o_rdata (char_rdata)
    );

    // one row per record: date length above summary length
    tsrs_ram #(
        .WIDTH (2 * CW),
        .DEPTH (MAX_RECORDS)
    ) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (len_waddr),
        .i_wdata (len_wdata),
        .i_re    (is_read),
        .i_raddr (len_raddr),
        .o_rdata (len_rdata)
    );

    // read data from the stores holds while the middle stage waits
    assign s1_len = r_s1_date ? len_rdata[2*CW-1:CW] : len_rdata[CW-1:0];
    assign s1_hit = r_s1_ok && ({{CW{1'b0}}, r_s1_pos} < {4'b0, s1_len});

    always_comb begin
        s1_item              = '0;
        if (r_s1_is_read) begin
            s1_item.read_char = s1_hit ? char_rdata : 8'd0;
        end else begin
            s1_item.done_res     = r_s1_done;
            s1_item.record_count = r_s1_count;
            s1_item.selection    = r_s1_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= tsrs_pkg::PH_SUM_FIRST;
            r_slot      <= '0;
            r_cp        <= '0;
            r_complete  <= '0;
            r_stopped   <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_slot     <= n_slot;
            r_cp       <= n_cp;
            r_complete <= n_complete;
            r_stopped  <= n_stopped;
            // an empty middle stage fills even while the output register waits
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum_len <= n_sum_len;
        if (advance) begin
            r_out_item <= s1_item;
        end
        if (in_accept) begin
            r_s1_is_read <= is_read;
            r_s1_ok      <= (int'(i_in_item.read_record) < MAX_RECORDS)
                            && (int'(i_in_item.read_position) < FIELD_CHARS);
            r_s1_date    <= i_in_item.read_is_date;
            r_s1_pos     <= i_in_item.read_position;
            r_s1_done    <= done;
            r_s1_count   <= cnt8[2:0];
            r_s1_sel     <= clamp8[2:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef SYNTH
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_complete) <= MAX_RECORDS)
        else $error("record count beyond record limit");

    a_full_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_slot) >= MAX_RECORDS) |-> r_stopped)
        else $error("record slot past limit while parsing");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_cp) <= FIELD_CHARS)
        else $error("character position past field size");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_s1_valid)
        else $error("accepted item lost before middle stage");
`endif

endmodule

`default_nettype wire

### sim/tb_tab_separated_record_splitter_core.sv
`timescale 1ns / 1ps

module tb_tab_separated_record_splitter_core;

    localparam int MAX_REC     = 5;
    localparam int FIELD_LEN   = 15;
    localparam int N_FIELDS    = 2 * MAX_REC;
    localparam int ITEM_TARGET = 850;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    tsrs_pkg::t_in_item  i_in_item = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    tsrs_pkg::t_out_item o_out_item;

    int tx_idle_pct = 35;
    int rx_idle_pct = 85;
    int n_sent = 0;
    logic [7:0] buf_bytes[$];

    tab_separated_record_splitter_core #(
        .MAX_RECORDS(MAX_REC),
        .FIELD_CHARS(FIELD_LEN)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in_item(i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item(o_out_item)
    );

    class splitter_scoreboard;
        tsrs_pkg::t_out_item due_results[$];
        logic [7:0]          field_chars[N_FIELDS][FIELD_LEN];
        logic [3:0]          field_len[N_FIELDS];
        bit                  len_known[N_FIELDS];
        tsrs_pkg::t_phase    phase;
        logic [2:0]          slot;
        logic [3:0]          pos;
        logic [2:0]          closed_recs;
        bit                  halted;
        int                  n_errors;

        function new();
            n_errors = 0;
            foreach (len_known[f]) begin
                len_known[f] = 1'b0;
                field_len[f] = '0;
            end
            clear_parse();
        endfunction

        function void clear_parse();
            phase = tsrs_pkg::PH_SUM_FIRST;
            slot = '0;
            pos = '0;
            closed_recs = '0;
            halted = 1'b0;
        endfunction

        function void store_char(int fld, logic [7:0] c);
            if (pos < FIELD_LEN) begin
                field_chars[fld][pos] = c;
                field_len[fld] = pos + 4'd1;
                len_known[fld] = 1'b1;
                pos = pos + 4'd1;
            end
        endfunction

        function void clear_len(int fld);
            field_len[fld] = '0;
            len_known[fld] = 1'b1;
        endfunction

        function void take_byte(logic [7:0] b);
            int sum_fld;
            sum_fld = slot * 2;
            if (halted || slot >= MAX_REC)
                return;
            if (b == tsrs_pkg::NUL_CHAR) begin
                halted = 1'b1;
                return;
            end
            case (phase)
                tsrs_pkg::PH_SUM_FIRST: begin
                    // first summary char is text even when it is a tab
                    pos = '0;
                    clear_len(sum_fld + 1);
                    store_char(sum_fld, b);
                    phase = tsrs_pkg::PH_SUM_REST;
                end
                tsrs_pkg::PH_SUM_REST: begin
                    if (b == tsrs_pkg::TAB_CHAR) begin
                        closed_recs = slot + 3'd1;
                        phase = tsrs_pkg::PH_DATE;
                        pos = '0;
                        clear_len(sum_fld + 1);
                    end else begin
                        store_char(sum_fld, b);
                    end
                end
                default: begin
                    if (b == tsrs_pkg::TAB_CHAR) begin
                        slot = slot + 3'd1;
                        phase = tsrs_pkg::PH_SUM_FIRST;
                        pos = '0;
                        if (slot >= MAX_REC)
                            halted = 1'b1;
                    end else begin
                        store_char(sum_fld + 1, b);
                    end
                end
            endcase
        endfunction

        function tsrs_pkg::t_out_item parse_or_read(tsrs_pkg::t_in_item it);
            tsrs_pkg::t_out_item r;
            int                  fld;
            logic [2:0]          s;
            r = '0;
            if (it.opcode == tsrs_pkg::OP_READ) begin
                if (it.read_record < MAX_REC) begin
                    fld = it.read_record * 2 + it.read_is_date;
                    if (it.read_position < field_len[fld])
                        r.read_char = field_chars[fld][it.read_position];
                end
                return r;
            end
            take_byte(it.data_byte);
            if (it.last_byte) begin
                s = it.current_selection;
                if (s >= closed_recs)
                    s = (closed_recs == 0) ? 3'd0 : closed_recs - 3'd1;
                r.done_res = 1'b1;
                r.record_count = closed_recs;
                r.selection = s;
                clear_parse();
            end
            return r;
        endfunction

        function void note_item(tsrs_pkg::t_in_item it);
            due_results.push_back(parse_or_read(it));
        endfunction

        task flag_mismatch(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            n_errors++;
        endtask

        task check_result(tsrs_pkg::t_out_item got);
            tsrs_pkg::t_out_item want;
            if (due_results.size() == 0) begin
                flag_mismatch($sformatf("result %h with nothing pending", got));
                return;
            end
            want = due_results.pop_front();
            if (got.read_char !== want.read_char)
                flag_mismatch($sformatf("read_char %h, want %h",
                                        got.read_char, want.read_char));
            if (got.done_res !== want.done_res)
                flag_mismatch($sformatf("done_res %b, want %b",
                                        got.done_res, want.done_res));
            if (got.record_count !== want.record_count)
                flag_mismatch($sformatf("record_count %0d, want %0d",
                                        got.record_count, want.record_count));
            if (got.selection !== want.selection)
                flag_mismatch($sformatf("selection %0d, want %0d",
                                        got.selection, want.selection));
        endtask
    endclass

    splitter_scoreboard sb;

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_out_item);
    end

    initial begin
        #1_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic tsrs_pkg::t_in_item parse_item(logic [7:0] b, logic last,
                                                      logic [2:0] sel);
        tsrs_pkg::t_in_item it;
        logic [31:0]        rnd;
        rnd = $urandom;
        it = rnd[$bits(tsrs_pkg::t_in_item)-1:0];
        it.opcode = tsrs_pkg::OP_PARSE;
        it.data_byte = b;
        it.last_byte = last;
        it.current_selection = sel;
        return it;
    endfunction

    function automatic tsrs_pkg::t_in_item read_item(logic [2:0] rec, logic is_date,
                                                     logic [3:0] at);
        tsrs_pkg::t_in_item it;
        logic [31:0]        rnd;
        rnd = $urandom;
        it = rnd[$bits(tsrs_pkg::t_in_item)-1:0];
        it.opcode = tsrs_pkg::OP_READ;
        it.read_record = rec;
        it.read_is_date = is_date;
        it.read_position = at;
        return it;
    endfunction

    // never read a field whose length was not yet written
    function automatic tsrs_pkg::t_in_item random_read();
        logic [2:0] rec;
        logic       dt;
        logic [3:0] at;
        int         tries;
        tries = 0;
        do begin
            rec = ($urandom_range(0, 9) < 9) ? 3'($urandom_range(0, 4))
                                             : 3'($urandom_range(5, 7));
            dt = 1'($urandom_range(0, 1));
            tries++;
        end while (rec < MAX_REC && !sb.len_known[rec * 2 + dt] && tries < 8);
        if (rec < MAX_REC && !sb.len_known[rec * 2 + dt])
            rec = 3'($urandom_range(5, 7));
        at = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                         : 4'($urandom_range(0, 4));
        return read_item(rec, dt, at);
    endfunction

    function automatic logic [7:0] text_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == tsrs_pkg::TAB_CHAR);
        return c;
    endfunction

    function automatic void add_text(int n, bit tab_first);
        for (int k = 0; k < n; k++)
            buf_bytes.push_back((k == 0 && tab_first) ? tsrs_pkg::TAB_CHAR : text_char());
    endfunction

    function automatic int field_size(bit is_date);
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(14, 19);
        return is_date ? $urandom_range(0, 4) : $urandom_range(1, 5);
    endfunction

    task automatic push_item(input tsrs_pkg::t_in_item it);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        sb.note_item(it);
        n_sent++;
    endtask

    task automatic send_bytes(input logic [2:0] sel);
        for (int i = 0; i < buf_bytes.size(); i++)
            push_item(parse_item(buf_bytes[i], i == buf_bytes.size() - 1, sel));
    endtask

    task automatic send_random_buffer();
        int n_rec;
        int r;
        buf_bytes.delete();
        if ($urandom_range(0, 9) == 0) begin
            // noise buffer
            repeat ($urandom_range(1, 20)) begin
                r = $urandom_range(0, 9);
                buf_bytes.push_back((r == 0) ? tsrs_pkg::NUL_CHAR
                                  : (r < 4) ? tsrs_pkg::TAB_CHAR
                                  : 8'($urandom_range(0, 255)));
            end
        end else begin
            n_rec = $urandom_range(0, 6);
            for (int i = 0; i < n_rec; i++) begin
                add_text(field_size(1'b0), $urandom_range(0, 7) == 0);
                buf_bytes.push_back(tsrs_pkg::TAB_CHAR);
                add_text(field_size(1'b1), 1'b0);
                buf_bytes.push_back(tsrs_pkg::TAB_CHAR);
            end
            case ($urandom_range(0, 4))
                0: ;
                1: buf_bytes.push_back(tsrs_pkg::TAB_CHAR);
                2: add_text(field_size(1'b0), $urandom_range(0, 7) == 0);
                3: begin
                    add_text(field_size(1'b0), 1'b0);
                    buf_bytes.push_back(tsrs_pkg::TAB_CHAR);
                    add_text(field_size(1'b1), 1'b0);
                end
                default: begin
                    buf_bytes.push_back(tsrs_pkg::NUL_CHAR);
                    add_text($urandom_range(0, 3), $urandom_range(0, 1) == 0);
                end
            endcase
            if (buf_bytes.size() == 0)
                buf_bytes.push_back(text_char());
        end
        send_bytes(3'($urandom_range(0, 7)));
    endtask

    initial begin
        int ph;
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // two records, the second summary opening with a tab, selection clamped
        buf_bytes = '{8'h41, tsrs_pkg::TAB_CHAR, 8'h31, tsrs_pkg::TAB_CHAR,
                      tsrs_pkg::TAB_CHAR, 8'h62, tsrs_pkg::TAB_CHAR, 8'h7a,
                      tsrs_pkg::TAB_CHAR};
        send_bytes(3'd7);
        push_item(read_item(3'd0, 1'b0, 4'd0));
        push_item(read_item(3'd0, 1'b0, 4'd1));
        push_item(read_item(3'd1, 1'b0, 4'd0));
        push_item(read_item(3'd1, 1'b1, 4'd0));
        push_item(read_item(3'd7, 1'b1, 4'd15));
        push_item(read_item(3'd0, 1'b0, 4'd15));
        // nul stops parsing, later bytes ignored
        buf_bytes = '{8'hff, tsrs_pkg::TAB_CHAR, tsrs_pkg::NUL_CHAR, 8'h78};
        send_bytes(3'd3);
        push_item(read_item(3'd0, 1'b0, 4'd0));
        // stale slot past the record count
        push_item(read_item(3'd1, 1'b0, 4'd1));
        buf_bytes = '{tsrs_pkg::NUL_CHAR};
        send_bytes(3'd0);

        for (ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 85 : 0;
            rx_idle_pct = (ph == 0) ? 85 : (ph == 1) ? 35 : 0;
            while (n_sent < (ph + 1) * ITEM_TARGET / 3) begin
                send_random_buffer();
                repeat ($urandom_range(0, 4))
                    push_item(random_read());
            end
        end
        i_in_valid <= 1'b0;

        while (sb.due_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### sim.f
src/tsrs_pkg.sv
src/tsrs_ram.sv
src/tab_separated_record_splitter_core.sv
sim/tb_tab_separated_record_splitter_core.sv
